// File: design/fp16g_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fp16g_pkg
// Shared types and constants for the FP16 BT.709 to BT.2020 gamut converter.
// ----------------------------------------------------------------------------
package fp16g_pkg;

  localparam int unsigned NumLanes = 3;

  // binary32 bit patterns of the matrix coefficients, row major
  localparam logic [31:0] Coef [0:8] = '{
    32'h3F209D8B, 32'h3EA897C8, 32'h3D316914,
    32'h3D8D82E3, 32'h3F6B6700, 32'h3C3A28F1,
    32'h3C8647AD, 32'h3DB44051, 32'h3F6545B8
  };

  localparam logic [15:0] Fp16Inf  = 16'h7C00;
  localparam logic [15:0] Fp16Qbit = 16'h0200;
  localparam logic [15:0] Fp16QNan = 16'h7E00;
  localparam logic [31:0] Fp32QNan = 32'h7FC00000;

  typedef logic [31:0] fp32_t;

  // binary32 product, round to nearest even, subnormal results kept
  function automatic fp32_t fp_mul(input fp32_t a, input fp32_t b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [10:0] e;
    logic [49:0] w;
    logic [5:0]  sh;
    logic [24:0] q;
    logic        g, st;
    logic [31:0] r;
    s  = a[31] ^ b[31];
    ea = a[30:23]; eb = b[30:23];
    ma = {(ea != 8'd0), a[22:0]};
    mb = {(eb != 8'd0), b[22:0]};
    r  = '0;
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
      r = Fp32QNan;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if ((ea == 8'hFF && b[30:0] == 0) || (eb == 8'hFF && a[30:0] == 0)) r = Fp32QNan;
      else r = {s, 8'hFF, 23'd0};
    end else if (a[30:0] == 0 || b[30:0] == 0) begin
      r = {s, 31'd0};
    end else begin
      // operands here come from decoded fp16 and normal constants: both normal
      p = ma * mb;
      e = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd127;
      if (p[47]) begin
        w = {p, 2'b00};
        e = e + 11'sd1;
      end else begin
        w = {p[46:0], 3'b000};
      end
      // w[49] is the leading one, mantissa w[49:26]
      if (e < 11'sd1) begin
        sh = (e < -11'sd25) ? 6'd26 : 6'(11'sd1 - e);
        st = |(w << (6'd50 - sh));
        w  = w >> sh;
        e  = 11'sd0;
      end else begin
        st = 1'b0;
      end
      q  = {1'b0, w[49:26]};
      g  = w[25];
      st = st | (|w[24:0]);
      if (g && (st || q[0])) q = q + 25'd1;
      if (e == 0) begin
        r = {s, 7'd0, q[23:0]};
      end else if (q[24]) begin
        e = e + 11'sd1;
        r = (e >= 11'sd255) ? {s, 8'hFF, 23'd0} : {s, e[7:0], 23'd0};
      end else begin
        r = (e >= 11'sd255) ? {s, 8'hFF, 23'd0} : {s, e[7:0], q[22:0]};
      end
    end
    return r;
  endfunction

  // binary32 sum, round to nearest even
  function automatic fp32_t fp_add(input fp32_t a, input fp32_t b);
    logic [7:0]  ea, eb, eh, el;
    logic [27:0] mh, ml;
    logic        sh_, sl;
    logic [8:0]  d;
    logic [28:0] sum;
    logic [4:0]  lz;
    logic signed [10:0] e;
    logic [28:0] n;
    logic [24:0] q;
    logic        g, st, found;
    logic [31:0] r;
    ea = a[30:23]; eb = b[30:23];
    r  = '0;
    lz = '0;
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
      r = Fp32QNan;
    end else if (ea == 8'hFF && eb == 8'hFF) begin
      r = (a[31] != b[31]) ? Fp32QNan : a;
    end else if (ea == 8'hFF) begin
      r = a;
    end else if (eb == 8'hFF) begin
      r = b;
    end else begin
      if (a[30:0] >= b[30:0]) begin
        eh = ea; el = eb; sh_ = a[31]; sl = b[31];
        mh = {1'b0, (ea != 0), a[22:0], 3'b000};
        ml = {1'b0, (eb != 0), b[22:0], 3'b000};
      end else begin
        eh = eb; el = ea; sh_ = b[31]; sl = a[31];
        mh = {1'b0, (eb != 0), b[22:0], 3'b000};
        ml = {1'b0, (ea != 0), a[22:0], 3'b000};
      end
      if (eh == 0) eh = 8'd1;
      if (el == 0) el = 8'd1;
      d = {1'b0, eh} - {1'b0, el};
      if (d > 9'd27) begin
        ml = {27'd0, |ml};
      end else begin
        ml = (ml >> d) | {27'd0, |(ml & ~({28{1'b1}} << d))};
      end
      if (sh_ == sl) sum = {1'b0, mh} + {1'b0, ml};
      else           sum = {1'b0, mh} - {1'b0, ml};
      if (sum == 0) begin
        r = {sh_ & sl, 31'd0};
      end else begin
        e = $signed({3'd0, eh});
        n = sum;
        if (n[27]) begin
          // carry out: leading one at bit 27, shift down one
          n = {1'b0, n[28:2], n[1] | n[0]};
          e = e + 11'sd1;
        end else begin
          found = 1'b0;
          for (int i = 26; i >= 0; i--) begin
            if (!found && n[i]) begin
              found = 1'b1;
              lz = 5'(26 - i);
            end
          end
          if (e - $signed({6'd0, lz}) >= 11'sd1) begin
            n = n << lz;
            e = e - $signed({6'd0, lz});
          end else begin
            n = n << (e - 11'sd1);
            e = 11'sd0;
          end
        end
        q  = {1'b0, n[26:3]};
        g  = n[2];
        st = n[1] | n[0];
        if (g && (st || q[0])) q = q + 25'd1;
        if (e == 0) begin
          r = {sh_, 7'd0, q[23:0]};
        end else if (q[24]) begin
          e = e + 11'sd1;
          r = (e >= 11'sd255) ? {sh_, 8'hFF, 23'd0} : {sh_, e[7:0], 23'd0};
        end else begin
          r = (e >= 11'sd255) ? {sh_, 8'hFF, 23'd0} : {sh_, e[7:0], q[22:0]};
        end
      end
    end
    return r;
  endfunction

endpackage : fp16g_pkg
`default_nettype wire

// File: design/fp16g_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fp16g_lane
// One matrix row: three products, two sums and fp16 encode, three stages.
// ----------------------------------------------------------------------------
module fp16g_lane #(
  parameter int unsigned Row = 0
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] r32,
  input  wire logic [31:0] g32,
  input  wire logic [31:0] b32,
  output logic [15:0]      res
);
  import fp16g_pkg::*;

  logic [31:0] p0, p1, p2, s01, p2d, acc;
  logic [7:0]  e32;

  assign e32 = acc[30:23];

  always_comb begin
    if (e32 == 8'hFF && acc[22:0] != 0) res = Fp16QNan;
    else if (e32 <= 8'd112) res = {acc[31], 15'd0};
    else if (e32 >= 8'd143)
      res = {acc[31], 15'd0} | Fp16Inf | ((acc[22:13] != 0) ? Fp16Qbit : 16'd0);
    else res = {acc[31], 5'(e32 - 8'd112), acc[22:13]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= fp_mul(Coef[Row*3+0], r32);
      p1  <= fp_mul(Coef[Row*3+1], g32);
      p2  <= fp_mul(Coef[Row*3+2], b32);
      s01 <= fp_add(p0, p1);
      p2d <= p2;
      acc <= fp_add(s01, p2d);
    end
  end
endmodule : fp16g_lane
`default_nettype wire

// File: design/fp16_rgb_bt709_to_bt2020.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fp16_rgb_bt709_to_bt2020
// FP16 RGBA gamut conversion from BT.709 to BT.2020 primaries.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock while the output
// is not stalled. Three lanes, one per output row, each run products then two
// sums; the whole pipeline is four register stages deep (decode, multiply,
// first sum, second sum) and the output is encoded from the second sum.
// The pipeline advances as a whole; a stall on the output holds every stage,
// and tready of the input follows whether the last stage can move.
// Alpha travels beside the lanes untouched. Subnormal fp16 inputs flush to
// signed zero; results are truncated to fp16 with underflow flushed.
module fp16_rgb_bt709_to_bt2020 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // red_in, green_in, blue_in, alpha_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // red_out, green_out, blue_out, alpha_out
);
  import fp16g_pkg::*;

  localparam int unsigned Depth = 4;

  logic [Depth-1:0] vld;
  logic             adv;
  logic [31:0]      r32, g32, b32;
  logic [15:0]      alpha [0:Depth-1];
  logic [15:0]      res [0:NumLanes-1];

  // advance when the final stage is empty or being taken
  assign adv      = !vld[Depth-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[Depth-1];
  assign m_tdata  = {alpha[Depth-1], res[2], res[1], res[0]};

  function automatic logic [31:0] dec16(input logic [15:0] h);
    if (h[14:10] == 5'd0) return {h[15], 31'd0};
    else if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
    else return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], s_tvalid};
    end
  end

  // hold decoded channels and alpha along the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      r32      <= dec16(s_tdata[15:0]);
      g32      <= dec16(s_tdata[31:16]);
      b32      <= dec16(s_tdata[47:32]);
      alpha[0] <= s_tdata[63:48];
      for (int i = 1; i < Depth; i++) alpha[i] <= alpha[i-1];
    end
  end

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    fp16g_lane #(.Row(k)) u_lane (
      .clk (clk),
      .en  (adv),
      .r32 (r32),
      .g32 (g32),
      .b32 (b32),
      .res (res[k])
    );
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res[0][14:10] == 5'd31 && res[0][8:0] != 0 |-> 1'b0)
    else $error("non-canonical NaN pattern on red");
endmodule : fp16_rgb_bt709_to_bt2020
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the FP16 BT.709 to BT.2020 gamut converter.
// ----------------------------------------------------------------------------
// Pixels go in on the slave stream and come back on the master stream in
// order. An integer model of binary32 multiply and add with round to nearest
// even computes each expected pixel. Every returned pixel is compared with the
// oldest expected one, channel by channel. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  // BT.709 to BT.2020 matrix as binary32 patterns, row major
  localparam logic [31:0] Gamut [0:8] = '{
    32'h3F209D8B, 32'h3EA897C8, 32'h3D316914,
    32'h3D8D82E3, 32'h3F6B6700, 32'h3C3A28F1,
    32'h3C8647AD, 32'h3DB44051, 32'h3F6545B8
  };
  localparam logic [31:0] QuietNan32 = 32'h7FC00000;
  localparam logic [15:0] Half1      = 16'h3C00;
  localparam logic [15:0] HalfInf    = 16'h7C00;
  localparam logic [15:0] HalfNan    = 16'h7E00;
  localparam logic [15:0] HalfMax    = 16'h7BFF;
  localparam logic [15:0] HalfMinNrm = 16'h0400;
  localparam logic [15:0] HalfSub    = 16'h03FF;
  localparam logic [15:0] HalfNeg    = 16'h8000;
  localparam int          WatchLimit = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // red_in, green_in, blue_in, alpha_in
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // red_out, green_out, blue_out, alpha_out

  pixel_t pending_pixels[$];
  int     mismatches;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     quiet_cycles;

  fp16_rgb_bt709_to_bt2020 u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    if (h[14:10] == 5'd0) return {h[15], 31'd0};
    if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic [7:0] ex;
    ex = f[30:23];
    if (ex == 8'hFF && f[22:0] != 0) return HalfNan;
    if (ex <= 8'd112) return {f[15+16], 15'd0};
    if (ex >= 8'd143) return {f[31], 15'd0} | HalfInf | (f[22:13] != 0 ? 16'h0200 : 16'h0);
    return {f[31], 5'(ex - 8'd112), f[22:13]};
  endfunction

  function automatic bit is_nan32(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 0;
  endfunction

  // operands are normal, zero, Inf or NaN here: fp16 decode never gives subnormals
  function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sg;
    logic [47:0]        prod;
    logic [24:0]        q;
    logic signed [11:0] ex;
    logic               g, st;
    sg = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return QuietNan32;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == 0 || b[30:0] == 0) return QuietNan32;
      return {sg, 8'hFF, 23'd0};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {sg, 31'd0};
    prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    ex = $signed({4'd0, a[30:23]}) + $signed({4'd0, b[30:23]}) - 12'sd127;
    if (prod[47]) ex = ex + 12'sd1;
    else prod = prod << 1;
    q  = {1'b0, prod[47:24]};
    g  = prod[23];
    st = |prod[22:0];
    if (g && (st || q[0])) q = q + 25'd1;
    if (q[24]) begin
      ex = ex + 12'sd1;
      q  = q >> 1;
    end
    if (ex >= 12'sd255) return {sg, 8'hFF, 23'd0};
    return {sg, ex[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        hi, lo;
    logic [63:0]        mh, ml, acc;
    logic [7:0]         d;
    logic [24:0]        q;
    logic signed [11:0] ex;
    logic               g, st;
    int                 lead;
    if (is_nan32(a) || is_nan32(b)) return QuietNan32;
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) return (a[31] != b[31]) ? QuietNan32 : a;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    if (a[30:0] >= b[30:0]) begin
      hi = a; lo = b;
    end else begin
      hi = b; lo = a;
    end
    d  = hi[30:23] - lo[30:23];
    mh = {1'b0, 1'b1, hi[22:0], 39'd0};
    ml = {1'b0, 1'b1, lo[22:0], 39'd0};
    if (d > 8'd62) ml = 64'd1;
    else ml = (ml >> d) | {63'd0, |(ml & ~({64{1'b1}} << d))};
    acc = (hi[31] == lo[31]) ? mh + ml : mh - ml;
    if (acc == 0) return 32'd0;
    lead = 0;
    for (int i = 0; i < 64; i++) begin
      if (acc[i]) lead = i;
    end
    acc = acc << (63 - lead);
    ex  = $signed({4'd0, hi[30:23]}) + 12'(lead - 62);
    q   = {1'b0, acc[63:40]};
    g   = acc[39];
    st  = |acc[38:0];
    if (g && (st || q[0])) q = q + 25'd1;
    if (q[24]) begin
      ex = ex + 12'sd1;
      q  = q >> 1;
    end
    if (ex >= 12'sd255) return {hi[31], 8'hFF, 23'd0};
    if (ex <= 12'sd0) return {hi[31], 31'd0};
    return {hi[31], ex[7:0], q[22:0]};
  endfunction

  function automatic pixel_t convert_gamut(input pixel_t px);
    logic [31:0] chan [0:2];
    logic [15:0] rows [0:2];
    logic [31:0] acc;
    chan[0] = half_to_single(px.red);
    chan[1] = half_to_single(px.green);
    chan[2] = half_to_single(px.blue);
    for (int k = 0; k < 3; k++) begin
      acc = single_add(single_mul(Gamut[3*k], chan[0]), single_mul(Gamut[3*k+1], chan[1]));
      acc = single_add(acc, single_mul(Gamut[3*k+2], chan[2]));
      rows[k] = single_to_half(acc);
    end
    return '{alpha: px.alpha, blue: rows[2], green: rows[1], red: rows[0]};
  endfunction

  // ------------------------------------------------------------------ drivers
  // Send one pixel; valid stays high across back-to-back items.
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = px;
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(convert_gamut(px));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Hold the sender until every expected pixel has come back.
  task automatic drain_pipeline();
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_half();
    logic [15:0] h;
    case ($urandom_range(9))
      0, 1:    h = 16'($urandom);
      2:       h = {1'($urandom_range(1)), 5'($urandom_range(1) ? 0 : 31), 10'($urandom)};
      3:       h = {1'($urandom_range(1)), 5'($urandom_range(1, 6)), 10'($urandom)};
      4:       h = {1'($urandom_range(1)), 5'($urandom_range(22, 30)), 10'($urandom)};
      default: h = {1'b0, 5'($urandom_range(8, 16)), 10'($urandom)};
    endcase
    return h;
  endfunction

  // ------------------------------------------------------------------ checker
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, got);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)
          $display("%0t: red expected %h actual %h", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %h actual %h", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
        if (got.alpha !== want.alpha)
          $display("%0t: alpha expected %h actual %h", $time, want.alpha, got.alpha);
        if (got !== want) mismatches++;
      end
    end
  end

  // Advance the watchdog only while work is outstanding and nothing moves.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else if (s_tvalid || pending_pixels.size() != 0) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_special_values();
    logic [15:0] specials [0:11];
    specials = '{16'h0000, HalfNeg, HalfSub, HalfSub | HalfNeg, HalfMinNrm, HalfMax,
                 HalfMax | HalfNeg, HalfInf, HalfInf | HalfNeg, HalfNan, 16'hFFFF, Half1};
    for (int i = 0; i < 12; i++) begin
      send_pixel('{alpha: specials[11 - i], blue: specials[i],
                   green: specials[(i + 4) % 12], red: specials[(i + 7) % 12]});
    end
    // Inf against -Inf inside one row sum gives NaN
    send_pixel('{alpha: 16'hFFFF, blue: 16'h0000, green: HalfInf | HalfNeg, red: HalfInf});
    send_pixel('{alpha: 16'h0000, blue: HalfInf, green: 16'h0000, red: HalfInf | HalfNeg});
    // tiny values underflow to signed zero
    send_pixel('{alpha: 16'h5555, blue: HalfMinNrm | HalfNeg, green: HalfNeg,
                 red: HalfMinNrm | HalfNeg});
    send_pixel('{alpha: 16'hAAAA, blue: Half1, green: Half1, red: Half1});
    send_pixel('{alpha: 16'h1234, blue: HalfMax, green: HalfMax, red: HalfMax});
    send_pixel('{alpha: 16'h8001, blue: 16'h7D55, green: Half1, red: 16'h3555});
  endtask

  task automatic test_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel('{alpha: 16'($urandom), blue: pick_half(), green: pick_half(),
                   red: pick_half()});
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 26;
    recv_idle_pct = 49;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_special_values();
    test_random_pixels(180);
    drain_pipeline();
    send_idle_pct = 49;
    recv_idle_pct = 26;
    test_random_pixels(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_pixels(220);

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/fp16g_pkg.sv
design/fp16g_lane.sv
design/fp16_rgb_bt709_to_bt2020.sv
sim/tb_top.sv
